// ===== hdl/u8dc_pkg.sv =====
// Package with the types, constants and character classes of the UTF-8 decoder.
`default_nettype none

package u8dc_pkg;

    localparam int unsigned CpWidth  = 21;
    localparam int unsigned LenWidth = 3;

    typedef logic [7:0]          byte_t;
    typedef logic [CpWidth-1:0]  code_point_t;
    typedef logic [LenWidth-1:0] seq_len_t;
    typedef logic [1:0]          left_t;

    localparam seq_len_t LenOne   = 3'd1;
    localparam seq_len_t LenTwo   = 3'd2;
    localparam seq_len_t LenThree = 3'd3;
    localparam seq_len_t LenFour  = 3'd4;

    localparam left_t LeftNone  = 2'd0;
    localparam left_t LeftOne   = 2'd1;
    localparam left_t LeftTwo   = 2'd2;
    localparam left_t LeftThree = 2'd3;

    function automatic logic is_space(input code_point_t cp);
        logic hit;
        hit = cp inside {21'h000020, 21'h001680, 21'h00180E, 21'h00205F, 21'h003000,
                         [21'h002000 : 21'h002006], [21'h002008 : 21'h00200D]};
        return hit;
    endfunction

    function automatic logic is_newline(input code_point_t cp);
        logic hit;
        hit = cp inside {[21'h00000A : 21'h00000D], 21'h000085, 21'h002028, 21'h002029};
        return hit;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8_decode_classify.sv =====
// Top level of the UTF-8 decoder with space and line-break classification.
//
//   channel   direction   handshake              payload
//   in        input       in_valid / in_stall    byte_in
//   out       output      out_valid / out_stall  code_point, seq_bytes, space_flag,
//                                                newline_flag, bad_lead
//
// One byte is accepted per cycle while in_stall is low; a result leaves after the byte that ends
// its sequence, through an input register and a result register.
// The decode of one byte against the open sequence state is the only logic between them.
// Reset clears the sequence state and both valid flags.
// A stalled result holds the pipeline; the input register still fills while it is empty, then holds its byte.
`default_nettype none

module utf8_decode_classify
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire u8dc_pkg::byte_t      byte_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output u8dc_pkg::code_point_t     code_point,
    output u8dc_pkg::seq_len_t        seq_bytes,
    output logic                      space_flag,
    output logic                      newline_flag,
    output logic                      bad_lead
);
    import u8dc_pkg::*;

    logic        byte_valid_reg;
    byte_t       byte_reg;
    left_t       left_reg,    left_next;
    code_point_t partial_reg, partial_next;
    seq_len_t    size_reg,    size_next;
    logic        res_valid_reg;
    code_point_t cp_reg;
    seq_len_t    len_reg;
    logic        space_reg, newline_reg, bad_reg;

    logic        out_busy;
    logic        decode_go;
    logic        emit;
    code_point_t emit_cp;
    seq_len_t    emit_len;
    logic        emit_bad;

    assign out_busy  = res_valid_reg && out_stall;
    assign decode_go = byte_valid_reg && !out_busy;
    assign in_stall  = byte_valid_reg && out_busy;

    always_comb
    begin
        left_next    = left_reg;
        partial_next = partial_reg;
        size_next    = size_reg;
        emit         = 1'b0;
        emit_cp      = '0;
        emit_len     = LenOne;
        emit_bad     = 1'b0;
        if (left_reg != LeftNone)
        begin
            partial_next = {partial_reg[CpWidth-7:0], byte_reg[5:0]};
            left_next    = left_reg - LeftOne;
            if (left_reg == LeftOne)
            begin
                emit     = 1'b1;
                emit_cp  = partial_next;
                emit_len = size_reg;
            end
        end
        else
        begin
            case (byte_reg) inside
                8'b0???????:
                begin
                    emit    = 1'b1;
                    emit_cp = {{(CpWidth-8){1'b0}}, byte_reg};
                end
                8'b110?????:
                begin
                    partial_next = {{(CpWidth-5){1'b0}}, byte_reg[4:0]};
                    left_next    = LeftOne;
                    size_next    = LenTwo;
                end
                8'b1110????:
                begin
                    partial_next = {{(CpWidth-4){1'b0}}, byte_reg[3:0]};
                    left_next    = LeftTwo;
                    size_next    = LenThree;
                end
                8'b11110???:
                begin
                    partial_next = {{(CpWidth-3){1'b0}}, byte_reg[2:0]};
                    left_next    = LeftThree;
                    size_next    = LenFour;
                end
                default:
                begin
                    emit     = 1'b1;
                    emit_bad = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            left_reg       <= LeftNone;
            partial_reg    <= '0;
            size_reg       <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                byte_valid_reg <= in_valid;
            end
            if (!out_busy)
            begin
                res_valid_reg <= decode_go && emit;
            end
            if (decode_go)
            begin
                left_reg    <= left_next;
                partial_reg <= partial_next;
                size_reg    <= size_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= byte_in;
        end
        if (decode_go && emit)
        begin
            cp_reg      <= emit_cp;
            len_reg     <= emit_len;
            bad_reg     <= emit_bad;
            space_reg   <= !emit_bad && is_space(emit_cp);
            newline_reg <= !emit_bad && is_newline(emit_cp);
        end
    end

    assign out_valid    = res_valid_reg;
    assign code_point   = cp_reg;
    assign seq_bytes    = len_reg;
    assign space_flag   = space_reg;
    assign newline_flag = newline_reg;
    assign bad_lead     = bad_reg;

    // An open sequence always has a length greater than the bytes it still expects.
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != LeftNone) |-> ({1'b0, left_reg} < size_reg))
        else $error("open sequence length is inconsistent with bytes left");

    // A bad lead byte gives code point zero, length one and no class flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && bad_reg) |->
            (cp_reg == '0 && len_reg == LenOne && !space_reg && !newline_reg))
        else $error("bad lead result carries wrong fields");

    // A result never claims to be both a space and a line break.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(space_reg && newline_reg))
        else $error("space and newline flags both set");

    // A result that was stalled is still there in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && out_stall) |=> (res_valid_reg && $stable(cp_reg)))
        else $error("stalled result was lost");

endmodule

`default_nettype wire
